/* rtl/elpp_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and the ease table generator for the lift position profile.
// No dependencies; eased_lift_position_profile imports this package.

package elpp_pkg;

  localparam int unsigned CosineTableBitsDef = 8;

  localparam int unsigned HeightW = 24;
  localparam int unsigned TimeW   = 16;
  localparam int unsigned PosW    = 18;
  localparam int unsigned SumW    = 19;
  localparam int unsigned EaseW   = 17;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CntW    = 5;
  localparam int unsigned ProdW   = 42;

  localparam logic signed [HeightW-1:0] HeightMax      = 24'sh7FFFFF;
  localparam logic signed [HeightW-1:0] HeightMin      = 24'sh800000;
  localparam logic signed [HeightW-1:0] MinGap         = 24'sd16;
  localparam logic signed [HeightW-1:0] BottomLiftMax  = HeightMax - MinGap;
  localparam logic [TimeW-1:0]          MinTime        = 16'd250;

  localparam logic signed [HeightW-1:0] DefBottom    = 24'sd0;
  localparam logic signed [HeightW-1:0] DefTop       = 24'sd4096;
  localparam logic [TimeW-1:0]          DefTravel    = 16'd1000;
  localparam logic [TimeW-1:0]          DefDwell     = 16'd1000;
  localparam logic [TimeW-1:0]          DefPhase     = 16'd0;
  localparam logic [TimeW-1:0]          DefSlab      = 16'd480;
  localparam logic [PosW-1:0]           DefPeriod    = 18'd4000;
  localparam logic [HeightW-1:0]        DefSpan      = 24'd4096;
  localparam logic [PosW-1:0]           DefPosition  = 18'd0;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BOTTOM_HEIGHT  = 3'd0,
    REG_TOP_HEIGHT     = 3'd1,
    REG_TRAVEL_TIME    = 3'd2,
    REG_DWELL_TIME     = 3'd3,
    REG_START_PHASE    = 3'd4,
    REG_SLAB_THICKNESS = 3'd5
  } elpp_reg_e;

  typedef enum logic [1:0] {
    SEG_REST_BOTTOM = 2'd0,
    SEG_RISING      = 2'd1,
    SEG_REST_TOP    = 2'd2,
    SEG_DESCENDING  = 2'd3
  } elpp_seg_e;

  typedef struct packed {
    logic [TimeW-1:0] elapsed_ms;
  } elpp_in_t;

  typedef struct packed {
    logic signed [HeightW-1:0] deck_top;
    logic signed [HeightW-1:0] slab_center;
    elpp_seg_e                 segment;
  } elpp_out_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [HeightW-1:0] value;
  } elpp_cfg_t;

  // Ease value for the first half of the table: sin^2 of a quarter turn scaled by i,
  // from a ninth order Taylor series in Q2.30, rounded to Q0.16.
  function automatic logic [EaseW-1:0] ease_low(int unsigned bits, int unsigned idx);
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] sq;
    a  = (64'd3373259426 * 64'(idx)) >> (bits + 1);
    a2 = (a * a) >> 30;
    t  = 64'd1073741824 - a2 / 64'd72;
    t  = 64'd1073741824 - ((a2 * t) >> 30) / 64'd42;
    t  = 64'd1073741824 - ((a2 * t) >> 30) / 64'd20;
    t  = 64'd1073741824 - ((a2 * t) >> 30) / 64'd6;
    s  = (a * t) >> 30;
    sq = (s * s + (64'd1 << 43)) >> 44;
    return sq[EaseW-1:0];
  endfunction

  // Full table entry; the upper half mirrors the lower half about one half.
  function automatic logic [EaseW-1:0] ease_entry(int unsigned bits, int unsigned idx);
    int unsigned size;
    size = 1 << bits;
    if (idx <= size / 2) begin
      return ease_low(bits, idx);
    end
    return 17'd65536 - ease_low(bits, size - idx);
  endfunction

endpackage

/* rtl/elpp_stream_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel carrying one payload struct per transfer.
// The payload type is set per instance, normally a struct from elpp_pkg.

interface elpp_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/eased_lift_position_profile.sv */
`timescale 1ns / 1ps
// Lift position profile: each input transfer carries the milliseconds elapsed since the
// previous one; the block advances its position within the period 2*(dwell+travel) and
// returns deck top height, slab center height and segment code. One shared subtractor
// runs a 19-step restoring modulo and then, while rising or descending, a
// COSINE_TABLE_BITS-step division for the table index. The input is not ready while an
// item is at work, but a finished result waits in the output register while the next
// item is taken. After reset the block is ready at once; after each register write it
// reloads its position through ST_PREP, ST_PERIOD and ST_LOAD.
// Depends on elpp_pkg and elpp_stream_if.

module eased_lift_position_profile #(
  parameter int unsigned COSINE_TABLE_BITS = elpp_pkg::CosineTableBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  elpp_stream_if.sink   in_if_i,
  elpp_stream_if.source out_if_o,
  elpp_stream_if.sink   cfg_if_i
);
  import elpp_pkg::*;

  localparam int unsigned TableSize = 1 << COSINE_TABLE_BITS;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_PERIOD,
    ST_LOAD,
    ST_MOD,
    ST_SEG_A,
    ST_SEG_B,
    ST_SEG_C,
    ST_DIV,
    ST_TAB,
    ST_MUL,
    ST_DECK,
    ST_OUT
  } state_e;

  state_e state_q;

  // Configuration registers and the values derived from them.
  logic signed [HeightW-1:0] bottom_q;
  logic signed [HeightW-1:0] top_q;
  logic [TimeW-1:0]          travel_q;
  logic [TimeW-1:0]          dwell_q;
  logic [TimeW-1:0]          phase_q;
  logic [TimeW-1:0]          slab_q;
  logic [TimeW-1:0]          tr_eff_q;
  logic [TimeW-1:0]          dw_eff_q;
  logic signed [HeightW-1:0] top_eff_q;
  logic [HeightW-1:0]        span_q;
  logic [PosW-1:0]           period_q;

  // Working registers.
  logic [PosW-1:0]              pos_q;
  logic [SumW-1:0]              sum_q;
  logic [PosW-1:0]              work_q;
  logic [CntW-1:0]              cnt_q;
  logic [COSINE_TABLE_BITS-1:0] quot_q;
  logic [EaseW-1:0]             ease_q;
  logic [ProdW-1:0]             prod_q;
  logic signed [HeightW-1:0]    deck_q;
  elpp_seg_e                    seg_q;
  elpp_out_t                    out_q;
  logic                         out_valid_q;

  logic [EaseW-1:0] ease_rom [TableSize];

  for (genvar g = 0; g < TableSize; g++) begin : g_rom
    assign ease_rom[g] = ease_entry(COSINE_TABLE_BITS, g);
  end

  logic in_fire;
  logic cfg_fire;
  logic out_free;
  logic out_load;

  // A register write takes priority, so no input transfer is taken in the same cycle.
  assign in_if_i.ready  = (state_q == ST_IDLE) && !cfg_if_i.valid;
  assign cfg_if_i.ready = 1'b1;
  assign in_fire        = in_if_i.valid && in_if_i.ready;
  assign cfg_fire       = cfg_if_i.valid;
  assign out_free       = !out_valid_q || out_if_o.ready;
  assign out_load       = !cfg_fire && (state_q == ST_OUT) && out_free;

  assign out_if_o.valid = out_valid_q;
  assign out_if_o.data  = out_q;

  // Shared subtractor: the borrow bit tells whether the first operand is below the second.
  logic [SumW-1:0] sub_a;
  logic [SumW-1:0] sub_b;
  logic [SumW:0]   sub_diff;
  logic            sub_borrow;

  always_comb begin
    case (state_q)
      ST_MOD: begin
        sub_a = {pos_q, sum_q[SumW-1]};
        sub_b = {1'b0, period_q};
      end
      ST_SEG_A: begin
        sub_a = {1'b0, pos_q};
        sub_b = {3'b0, dw_eff_q};
      end
      ST_SEG_B: begin
        sub_a = {1'b0, work_q};
        sub_b = {3'b0, tr_eff_q};
      end
      ST_SEG_C: begin
        sub_a = {1'b0, work_q};
        sub_b = {3'b0, dw_eff_q};
      end
      ST_DIV: begin
        sub_a = {work_q, 1'b0};
        sub_b = {3'b0, tr_eff_q};
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  assign sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_borrow = sub_diff[SumW];

  // Shared multiplier: phase times period on reload, span times ease while moving.
  logic [HeightW-1:0] mul_a;
  logic [PosW-1:0]    mul_b;
  logic [ProdW-1:0]   mul_p;

  always_comb begin
    if (state_q == ST_LOAD) begin
      mul_a = {8'b0, phase_q};
      mul_b = period_q;
    end else begin
      mul_a = span_q;
      mul_b = {1'b0, ease_q};
    end
  end

  assign mul_p = mul_a * mul_b;

  // Derived configuration values.
  logic signed [HeightW-1:0] top_lim;
  logic [TimeW:0]            time_sum;
  logic [HeightW:0]          span_diff;

  assign top_lim   = (bottom_q > BottomLiftMax) ? HeightMax : bottom_q + MinGap;
  assign time_sum  = {1'b0, tr_eff_q} + {1'b0, dw_eff_q};
  assign span_diff = {top_eff_q[HeightW-1], top_eff_q} - {bottom_q[HeightW-1], bottom_q};

  // Deck height from the scaled ease value, and the saturated slab center.
  logic [HeightW-1:0] ease_off;
  logic [HeightW:0]   deck_up;
  logic [HeightW:0]   deck_down;
  logic [HeightW:0]   ctr_full;
  logic [HeightW-1:0] ctr_sat;

  assign ease_off  = prod_q[HeightW+15:16];
  assign deck_up   = {bottom_q[HeightW-1], bottom_q} + {1'b0, ease_off};
  assign deck_down = {top_eff_q[HeightW-1], top_eff_q} - {1'b0, ease_off};
  assign ctr_full  = {deck_q[HeightW-1], deck_q} - {10'b0, slab_q[TimeW-1:1]};
  assign ctr_sat   = (ctr_full[HeightW] != ctr_full[HeightW-1]) ? HeightMin
                                                                : ctr_full[HeightW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bottom_q    <= DefBottom;
      top_q       <= DefTop;
      travel_q    <= DefTravel;
      dwell_q     <= DefDwell;
      phase_q     <= DefPhase;
      slab_q      <= DefSlab;
      tr_eff_q    <= DefTravel;
      dw_eff_q    <= DefDwell;
      top_eff_q   <= DefTop;
      span_q      <= DefSpan;
      period_q    <= DefPeriod;
      pos_q       <= DefPosition;
      sum_q       <= '0;
      work_q      <= '0;
      cnt_q       <= '0;
      quot_q      <= '0;
      ease_q      <= '0;
      prod_q      <= '0;
      deck_q      <= '0;
      seg_q       <= SEG_REST_BOTTOM;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_if_o.ready) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_fire) begin
        // Any listed register reloads the position; other indices are ignored.
        unique case (cfg_if_i.data.index)
          REG_BOTTOM_HEIGHT: begin
            bottom_q <= cfg_if_i.data.value;
            state_q  <= ST_PREP;
          end
          REG_TOP_HEIGHT: begin
            top_q   <= cfg_if_i.data.value;
            state_q <= ST_PREP;
          end
          REG_TRAVEL_TIME: begin
            travel_q <= cfg_if_i.data.value[TimeW-1:0];
            state_q  <= ST_PREP;
          end
          REG_DWELL_TIME: begin
            dwell_q <= cfg_if_i.data.value[TimeW-1:0];
            state_q <= ST_PREP;
          end
          REG_START_PHASE: begin
            phase_q <= cfg_if_i.data.value[TimeW-1:0];
            state_q <= ST_PREP;
          end
          REG_SLAB_THICKNESS: begin
            slab_q  <= cfg_if_i.data.value[TimeW-1:0];
            state_q <= ST_PREP;
          end
          default: begin
          end
        endcase
      end else begin
        unique case (state_q)
          ST_IDLE: begin
            if (in_fire) begin
              sum_q   <= {1'b0, pos_q} + {3'b0, in_if_i.data.elapsed_ms};
              pos_q   <= '0;
              cnt_q   <= CntW'(SumW - 1);
              state_q <= ST_MOD;
            end
          end
          ST_PREP: begin
            tr_eff_q  <= (travel_q < MinTime) ? MinTime : travel_q;
            dw_eff_q  <= (dwell_q < MinTime) ? MinTime : dwell_q;
            top_eff_q <= (top_q > top_lim) ? top_q : top_lim;
            state_q   <= ST_PERIOD;
          end
          ST_PERIOD: begin
            period_q <= {time_sum, 1'b0};
            span_q   <= span_diff[HeightW-1:0];
            state_q  <= ST_LOAD;
          end
          ST_LOAD: begin
            pos_q   <= mul_p[PosW+15:16];
            state_q <= ST_IDLE;
          end
          ST_MOD: begin
            // Restoring remainder, one dividend bit per cycle while no register write comes in, kept in pos_q.
            pos_q <= sub_borrow ? sub_a[PosW-1:0] : sub_diff[PosW-1:0];
            sum_q <= {sum_q[SumW-2:0], 1'b0};
            if (cnt_q == '0) begin
              state_q <= ST_SEG_A;
            end else begin
              cnt_q <= cnt_q - 1'b1;
            end
          end
          ST_SEG_A: begin
            if (sub_borrow) begin
              seg_q   <= SEG_REST_BOTTOM;
              deck_q  <= bottom_q;
              state_q <= ST_OUT;
            end else begin
              work_q  <= sub_diff[PosW-1:0];
              state_q <= ST_SEG_B;
            end
          end
          ST_SEG_B: begin
            if (sub_borrow) begin
              seg_q   <= SEG_RISING;
              cnt_q   <= CntW'(COSINE_TABLE_BITS - 1);
              state_q <= ST_DIV;
            end else begin
              work_q  <= sub_diff[PosW-1:0];
              state_q <= ST_SEG_C;
            end
          end
          ST_SEG_C: begin
            if (sub_borrow) begin
              seg_q   <= SEG_REST_TOP;
              deck_q  <= top_eff_q;
              state_q <= ST_OUT;
            end else begin
              seg_q   <= SEG_DESCENDING;
              work_q  <= sub_diff[PosW-1:0];
              cnt_q   <= CntW'(COSINE_TABLE_BITS - 1);
              state_q <= ST_DIV;
            end
          end
          ST_DIV: begin
            // Time into the move scaled by the table size, divided by the travel time.
            work_q <= sub_borrow ? sub_a[PosW-1:0] : sub_diff[PosW-1:0];
            quot_q <= {quot_q[COSINE_TABLE_BITS-2:0], !sub_borrow};
            if (cnt_q == '0) begin
              state_q <= ST_TAB;
            end else begin
              cnt_q <= cnt_q - 1'b1;
            end
          end
          ST_TAB: begin
            ease_q  <= ease_rom[quot_q];
            state_q <= ST_MUL;
          end
          ST_MUL: begin
            prod_q  <= mul_p + ProdW'(32768);
            state_q <= ST_DECK;
          end
          ST_DECK: begin
            deck_q  <= (seg_q == SEG_RISING) ? deck_up[HeightW-1:0] : deck_down[HeightW-1:0];
            state_q <= ST_OUT;
          end
          ST_OUT: begin
            if (out_free) begin
              out_q.deck_top    <= deck_q;
              out_q.slab_center <= ctr_sat;
              out_q.segment     <= seg_q;
              state_q           <= ST_IDLE;
            end
          end
          default: begin
            state_q <= ST_IDLE;
          end
        endcase
      end
    end
  end

endmodule
